// ===== rtl/urpt_pkg.sv =====
// Shared types and constants for the UDP port relay token policer.
// No dependencies; imported by every module of the block.
package urpt_pkg;

    localparam int PORT_AW = 16;

    localparam logic [15:0] MIN_FRAME  = 16'd42;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    localparam logic [7:0]  RATE_RESET  = 8'd1;
    localparam logic [31:0] BURST_RESET = 32'd10485760;
    localparam logic [7:0]  QUOTA_RESET = 8'd3;

    typedef enum logic [1:0] {
        V_PASS = 2'd0,
        V_DROP = 2'd1,
        V_TX   = 2'd2
    } t_verdict;

    typedef enum logic [1:0] {
        CFG_RATE  = 2'd0,
        CFG_BURST = 2'd1,
        CFG_QUOTA = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic        valid;
        logic [31:0] tokens;
        logic [63:0] last_time;
        logic [31:0] home_addr;
        logic [15:0] reply_port;
    } t_port_rec;

    typedef struct packed {
        logic [31:0] source;
        logic [7:0]  count;
    } t_quota_rec;

endpackage

// ===== rtl/udp_port_relay_token_policer_top.sv =====
// Top level of the UDP port relay token policer: control sequencer and config.
// Depends on urpt_pkg, urpt_port_mem and urpt_quota_mem.
//
// Usage: one parsed frame descriptor is taken per input transfer (valid and
// ready) and exactly one verdict is given per output transfer. Items are
// handled one at a time. A frame that is not a UDP/IPv4 frame of at least
// 42 bytes goes from input transfer straight to the done state. A frame to
// a registered port passes through port record read, elapsed time, refill
// product, clamp and police with write-back. A registration frame scans the
// quota entries in use, one entry per read-compare pair, on the single read
// port of the quota table; the scan stops early when the source is found.
// The output register holds a finished verdict while the receiver
// stalls; the next item waits in the sequencer until that register frees.
// After reset the port store is swept to mark all 65536 ports unregistered;
// input ready stays low during the sweep, while config writes are taken at
// any time. Config registers return to their defaults.
module udp_port_relay_token_policer_top #(
    parameter int QUOTA_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_frame_length,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_ip_proto,
    input  logic [31:0] i_source_addr,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic [63:0] i_now_ns,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_verdict,
    output logic [31:0] o_new_dest_addr,
    output logic [15:0] o_new_dest_port,
    output logic        o_registered
);
    import urpt_pkg::*;

    localparam int QAW = (QUOTA_ENTRIES > 1) ? $clog2(QUOTA_ENTRIES) : 1;
    localparam int QFW = $clog2(QUOTA_ENTRIES + 1);
    localparam logic [QFW-1:0] QFULL = QFW'(QUOTA_ENTRIES);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_LOOK   = 9'b000000100,
        S_PROD   = 9'b000001000,
        S_CLAMP  = 9'b000010000,
        S_POLICE = 9'b000100000,
        S_QRD    = 9'b001000000,
        S_QCMP   = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [7:0]  r_rate;
    logic [31:0] r_burst;
    logic [7:0]  r_qlimit;

    logic [15:0] r_len, r_sport, r_dport;
    logic [31:0] r_src;
    logic [63:0] r_now;

    logic [15:0] r_clr, n_clr;
    t_port_rec   r_rec, n_rec;
    logic [63:0] r_elapsed, n_elapsed;
    logic [39:0] r_prod, n_prod;
    logic [31:0] r_tok, n_tok;
    logic [QFW-1:0] r_qfill, n_qfill;
    logic [QFW-1:0] r_qi, n_qi;
    logic        r_hit, n_hit;
    logic [7:0]  r_hit_cnt, n_hit_cnt;
    logic        r_decide, n_decide;

    t_verdict    r_res_v, n_res_v;
    logic [31:0] r_res_a, n_res_a;
    logic [15:0] r_res_p, n_res_p;
    logic        r_res_r, n_res_r;

    logic        r_out_valid, n_out_valid;
    t_verdict    r_out_v, n_out_v;
    logic [31:0] r_out_a, n_out_a;
    logic [15:0] r_out_p, n_out_p;
    logic        r_out_r, n_out_r;

    logic        pm_we;
    logic [15:0] pm_waddr, pm_raddr;
    t_port_rec   pm_wdata, pm_rdata;
    logic        qm_we;
    logic [QAW-1:0] qm_waddr;
    t_quota_rec  qm_wdata, qm_rdata;

    logic        in_xfer;
    logic        is_udp;
    logic [40:0] sum;

    urpt_port_mem u_port_mem (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (pm_waddr),
        .i_wdata (pm_wdata),
        .i_raddr (pm_raddr),
        .o_rdata (pm_rdata)
    );

    urpt_quota_mem #(
        .ENTRIES (QUOTA_ENTRIES),
        .AW      (QAW)
    ) u_quota_mem (
        .i_clk   (i_clk),
        .i_we    (qm_we),
        .i_waddr (qm_waddr),
        .i_wdata (qm_wdata),
        .i_raddr (r_qi[QAW-1:0]),
        .o_rdata (qm_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign is_udp     = (i_frame_length >= MIN_FRAME) && (i_ether_type == ETYPE_IPV4)
                        && (i_ip_proto == PROTO_UDP);
    assign pm_raddr   = i_dest_port;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= RATE_RESET;
            r_burst  <= BURST_RESET;
            r_qlimit <= QUOTA_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RATE:  r_rate   <= i_cfg_data[7:0];
                CFG_BURST: r_burst  <= i_cfg_data;
                CFG_QUOTA: r_qlimit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_len   <= i_frame_length;
            r_src   <= i_source_addr;
            r_sport <= i_source_port;
            r_dport <= i_dest_port;
            r_now   <= i_now_ns;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_rec       = r_rec;
        n_elapsed   = r_elapsed;
        n_prod      = r_prod;
        n_tok       = r_tok;
        n_qfill     = r_qfill;
        n_qi        = r_qi;
        n_hit       = r_hit;
        n_hit_cnt   = r_hit_cnt;
        n_decide    = 1'b0;
        n_res_v     = r_res_v;
        n_res_a     = r_res_a;
        n_res_p     = r_res_p;
        n_res_r     = r_res_r;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_v     = r_out_v;
        n_out_a     = r_out_a;
        n_out_p     = r_out_p;
        n_out_r     = r_out_r;
        pm_we       = 1'b0;
        pm_waddr    = r_dport;
        pm_wdata    = r_rec;
        qm_we       = 1'b0;
        qm_waddr    = r_qfill[QAW-1:0];
        qm_wdata    = '{source: r_src, count: 8'd1};
        sum         = '0;

        case (r_state)
            S_CLEAR: begin
                pm_we    = 1'b1;
                pm_waddr = r_clr;
                pm_wdata = '0;
                n_clr    = r_clr + 16'd1;
                if (r_clr == 16'hFFFF) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_res_v = V_PASS;
                    n_res_a = '0;
                    n_res_p = '0;
                    n_res_r = 1'b0;
                    n_state = is_udp ? S_LOOK : S_DONE;
                end
            end
            S_LOOK: begin
                n_rec     = pm_rdata;
                n_elapsed = r_now - pm_rdata.last_time;
                n_hit     = 1'b0;
                n_qi      = '0;
                if (pm_rdata.valid) begin
                    n_state = S_PROD;
                end else if (r_qfill == '0) begin
                    n_decide = 1'b1;
                    n_state  = S_QCMP;
                end else begin
                    n_state = S_QRD;
                end
            end
            S_PROD: begin
                n_prod  = r_elapsed[31:0] * r_rate;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                if (r_elapsed == 64'd0) begin
                    n_tok = r_rec.tokens;
                end else if (r_rate == 8'd0) begin
                    n_tok = (r_rec.tokens > r_burst) ? r_burst : r_rec.tokens;
                end else if (r_elapsed[63:32] != 32'd0) begin
                    n_tok = r_burst;
                end else begin
                    sum   = {9'd0, r_rec.tokens} + {1'b0, r_prod};
                    n_tok = (sum > {9'd0, r_burst}) ? r_burst : sum[31:0];
                end
                n_state = S_POLICE;
            end
            S_POLICE: begin
                pm_we = 1'b1;
                pm_wdata = r_rec;
                if (r_elapsed != 64'd0) begin
                    pm_wdata.last_time = r_now;
                end
                if (r_tok < {16'd0, r_len}) begin
                    pm_wdata.tokens = r_tok;
                    n_res_v = V_DROP;
                end else begin
                    pm_wdata.tokens = r_tok - {16'd0, r_len};
                    n_res_v = V_TX;
                    n_res_a = r_rec.home_addr;
                    n_res_p = r_rec.reply_port;
                end
                n_state = S_DONE;
            end
            S_QRD: begin
                n_state = S_QCMP;
            end
            S_QCMP: begin
                if (!r_decide && (qm_rdata.source == r_src)) begin
                    n_hit     = 1'b1;
                    n_hit_cnt = qm_rdata.count;
                    n_decide  = 1'b1;
                end else if (!r_decide) begin
                    n_qi = r_qi + QFW'(1);
                    if (r_qi + QFW'(1) == r_qfill) begin
                        n_decide = 1'b1;
                    end else begin
                        n_state = S_QRD;
                    end
                end else begin
                    n_res_v = V_DROP;
                    if (!(r_hit && (r_hit_cnt >= r_qlimit))) begin
                        pm_we    = 1'b1;
                        pm_wdata = '{valid: 1'b1, tokens: r_burst, last_time: r_now,
                                     home_addr: r_src, reply_port: r_sport};
                        n_res_r  = 1'b1;
                        if (r_hit) begin
                            qm_we    = (r_hit_cnt != 8'hFF);
                            qm_waddr = r_qi[QAW-1:0];
                            qm_wdata = '{source: r_src, count: r_hit_cnt + 8'd1};
                        end else if (r_qfill != QFULL) begin
                            qm_we   = 1'b1;
                            n_qfill = r_qfill + QFW'(1);
                        end
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_v     = r_res_v;
                    n_out_a     = r_res_a;
                    n_out_p     = r_res_p;
                    n_out_r     = r_res_r;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_qfill     <= '0;
            r_out_valid <= 1'b0;
            r_decide    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_qfill     <= n_qfill;
            r_out_valid <= n_out_valid;
            r_decide    <= n_decide;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec     <= n_rec;
        r_elapsed <= n_elapsed;
        r_prod    <= n_prod;
        r_tok     <= n_tok;
        r_qi      <= n_qi;
        r_hit     <= n_hit;
        r_hit_cnt <= n_hit_cnt;
        r_res_v   <= n_res_v;
        r_res_a   <= n_res_a;
        r_res_p   <= n_res_p;
        r_res_r   <= n_res_r;
        r_out_v   <= n_out_v;
        r_out_a   <= n_out_a;
        r_out_p   <= n_out_p;
        r_out_r   <= n_out_r;
    end

    assign o_out_valid     = r_out_valid;
    assign o_verdict       = r_out_v;
    assign o_new_dest_addr = r_out_a;
    assign o_new_dest_port = r_out_p;
    assign o_registered    = r_out_r;

    a_reg_is_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_registered |-> o_verdict == V_DROP)
        else $error("registration frame not dropped");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qfill <= QFULL)
        else $error("quota fill count beyond table size");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_in_ready)
        else $error("second item taken while one is in flight");

    a_tx_has_zero_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_verdict == V_PASS |-> o_new_dest_addr == 32'd0 && !o_registered)
        else $error("pass verdict carries rewrite data");
endmodule

// ===== rtl/urpt_port_mem.sv =====
// Per-port registration store: 65536 records, one write and one read port.
// Read data is registered. Depends on urpt_pkg.
module urpt_port_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [15:0]                i_waddr,
    input  urpt_pkg::t_port_rec        i_wdata,
    input  logic [15:0]                i_raddr,
    output urpt_pkg::t_port_rec        o_rdata
);
    import urpt_pkg::*;

    t_port_rec r_mem [0:(1 << PORT_AW) - 1];
    t_port_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/urpt_quota_mem.sv =====
// Per-source quota table: source address and registration count per entry.
// Read data is registered. Depends on urpt_pkg.
module urpt_quota_mem #(
    parameter int ENTRIES = 16,
    parameter int AW      = 4
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  urpt_pkg::t_quota_rec       i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output urpt_pkg::t_quota_rec       o_rdata
);
    import urpt_pkg::*;

    t_quota_rec r_mem [0:ENTRIES-1];
    t_quota_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
